@@ sv/csiw_pkg.sv @@
// csiw_pkg: field positions, widths and types for the packed CSI word to double converter.
// No dependencies; imported by csiw_part_conv and csi_word_to_double_pair.
package csiw_pkg;

	localparam int unsigned WORD_W     = 32;
	localparam int unsigned DBL_W      = 64;
	localparam int unsigned MAG_W      = 11;
	localparam int unsigned FRAC_W     = 10;
	localparam int unsigned SEXP_W     = 6;
	localparam int unsigned EXPO_W     = 11;
	localparam int unsigned SHIFT_W    = 4;

	localparam int unsigned REAL_SIGN_POS = 29;
	localparam int unsigned REAL_MAG_POS  = 18;
	localparam int unsigned IMAG_SIGN_POS = 17;
	localparam int unsigned IMAG_MAG_POS  = 6;

	// 1023 - 31: rebias from the shared exponent to the double's exponent field
	localparam logic [EXPO_W-1:0] EXP_BIAS_OFFSET = 11'd992;

	localparam int unsigned FRAC_POS = 42;
	localparam int unsigned EXPO_POS = 52;
	localparam int unsigned SIGN_POS = 63;

	localparam logic [EXPO_W-1:0] EXPO_MIN_NONZERO = 11'd982;

	// one signed-magnitude part of the packed word
	typedef struct packed {
		logic             sign;
		logic [MAG_W-1:0] mag;
	} part_t;

endpackage

@@ sv/csi_word_to_double_pair.sv @@
// csi_word_to_double_pair: packed shared-exponent complex word to a pair of IEEE-754 doubles.
// Top level; depends on csiw_pkg and csiw_part_conv.
//
// Channel   Dir  Width  Contents
// s_axis    in   32     packed_word
// m_axis    out  128    real_double_bits [63:0], imag_double_bits [127:64]
//
// One item per cycle sustained while m_axis_tready is high; an accepted item goes into s1,
// then loads s2 when s2 can take it, and m_axis_tvalid rises with it (two registers deep).
// Stage s1 registers the input word, the two part converters sit between s1 and
// the output register s2, each a leading-one search over 11 bits and an 11-bit add.
// Each stage loads when empty or when the stage after it drains in the same cycle,
// so a full pipe keeps streaming while m_axis_tready stays high.
// m_axis_tready low holds s2, then s1 fills and s_axis_tready drops.
// arst_n clears both valid flags; data registers are not reset. Nothing else to reset.
module csi_word_to_double_pair (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [31:0]  s_axis_tdata,   // [31:0] packed_word
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [127:0] m_axis_tdata    // [63:0] real_double_bits, [127:64] imag_double_bits
);
	import csiw_pkg::*;

	logic              vld_s1;
	logic [WORD_W-1:0] word_s1;
	logic              vld_s2;
	logic [DBL_W-1:0]  real_s2;
	logic [DBL_W-1:0]  imag_s2;

	logic              load_s1;
	logic              load_s2;
	part_t             real_part;
	part_t             imag_part;
	logic [SEXP_W-1:0] sexp;
	logic [DBL_W-1:0]  real_dbl;
	logic [DBL_W-1:0]  imag_dbl;

	// ready chain: a stage takes a new item when empty or when it empties this cycle
	assign load_s2       = !vld_s2 || m_axis_tready;
	assign s_axis_tready = !vld_s1 || load_s2;
	assign load_s1       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			word_s1 <= s_axis_tdata;
		end
	end

	// unpack the fields of the registered word
	assign real_part.sign = word_s1[REAL_SIGN_POS];
	assign real_part.mag  = word_s1[REAL_MAG_POS +: MAG_W];
	assign imag_part.sign = word_s1[IMAG_SIGN_POS];
	assign imag_part.mag  = word_s1[IMAG_MAG_POS +: MAG_W];
	assign sexp           = word_s1[SEXP_W-1:0];

	csiw_part_conv u_real_conv (
		.part (real_part),
		.sexp (sexp),
		.dbl  (real_dbl)
	);

	csiw_part_conv u_imag_conv (
		.part (imag_part),
		.sexp (sexp),
		.dbl  (imag_dbl)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (load_s2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2 && vld_s1) begin
			real_s2 <= real_dbl;
			imag_s2 <= imag_dbl;
		end
	end

	assign m_axis_tvalid = vld_s2;
	assign m_axis_tdata  = {imag_s2, real_s2};

	// an item in s1 moves on whenever s2 can take it
	a_s1_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && load_s2) |=> m_axis_tvalid)
		else $error("s1 item not passed to output register");

	// a zero real magnitude leaves only the sign bit set
	a_real_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && load_s2 && (word_s1[REAL_MAG_POS +: MAG_W] == '0))
		|=> (m_axis_tdata[SIGN_POS-1:0] == '0))
		else $error("zero real magnitude did not give signed zero");

	// a nonzero imaginary magnitude always gives a normal exponent at or above the floor
	a_imag_expo: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && load_s2 && (word_s1[IMAG_MAG_POS +: MAG_W] != '0))
		|=> (m_axis_tdata[DBL_W + EXPO_POS +: EXPO_W] >= EXPO_MIN_NONZERO))
		else $error("imaginary exponent below normal floor");

	// low mantissa bits of both parts are always zero on a valid result
	a_low_frac: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ((m_axis_tdata[FRAC_POS-1:0] == '0)
			&& (m_axis_tdata[DBL_W +: FRAC_POS] == '0)))
		else $error("low mantissa bits not zero");

	// an accept never overwrites an item that cannot move on
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load_s1 |-> (!vld_s1 || load_s2))
		else $error("input accepted over a stalled s1 item");

endmodule

@@ sv/csiw_part_conv.sv @@
// csiw_part_conv: one signed 11-bit magnitude plus shared exponent to a double bit pattern.
// Combinational; depends on csiw_pkg.
module csiw_part_conv (
	input  csiw_pkg::part_t                   part,
	input  logic [csiw_pkg::SEXP_W-1:0]       sexp,
	output logic [csiw_pkg::DBL_W-1:0]        dbl
);
	import csiw_pkg::*;

	logic [SHIFT_W-1:0] lz;
	logic [MAG_W-1:0]   norm;
	logic [EXPO_W-1:0]  expo;

	// leading-one search: highest set bit wins
	always_comb begin
		lz = SHIFT_W'(MAG_W - 1);
		for (int i = 0; i < MAG_W; i++) begin
			if (part.mag[i]) begin
				lz = SHIFT_W'(MAG_W - 1 - i);
			end
		end
	end

	assign norm = part.mag << lz;
	assign expo = EXPO_W'(sexp) + EXP_BIAS_OFFSET - EXPO_W'(lz);

	always_comb begin
		dbl           = '0;
		dbl[SIGN_POS] = part.sign;
		if (part.mag != '0) begin
			dbl[FRAC_POS +: FRAC_W] = norm[FRAC_W-1:0];
			dbl[EXPO_POS +: EXPO_W] = expo;
		end
	end

endmodule

@@ bench/tb_csi_word_to_double_pair.sv @@
`timescale 1ns / 1ps
// tb_csi_word_to_double_pair: self-checking bench for the packed CSI word to double pair converter.
// Depends on csiw_pkg and csi_word_to_double_pair; directed table first, then random words.
module tb_csi_word_to_double_pair;
	import csiw_pkg::*;

	localparam int RANDOM_WORDS = 1730;
	localparam int IDLE_LIMIT   = 4000;  // cycles with no item moving on either side
	localparam int DRAIN_CYCLES = 8;     // pipe is two deep
	localparam int HOLD_AFTER   = 400;   // results seen before the long receiver hold
	localparam int HOLD_CYCLES  = 200;

	typedef struct packed {
		logic [DBL_W-1:0] re_bits;
		logic [DBL_W-1:0] im_bits;
	} double_pair_t;

	typedef struct packed {
		logic [WORD_W-1:0] word;
		bit                known;    // expected pair typed in below
		logic [DBL_W-1:0]  re_bits;
		logic [DBL_W-1:0]  im_bits;
	} stim_row_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          s_axis_tvalid = 1'b0;
	logic          s_axis_tready;
	logic [31:0]   s_axis_tdata = '0;  // [31:0] packed_word
	logic          m_axis_tvalid;
	logic          m_axis_tready = 1'b0;
	logic [127:0]  m_axis_tdata;       // [63:0] real_double_bits, [127:64] imag_double_bits

	double_pair_t  pending_doubles[$];
	stim_row_t     stim_rows[$];
	int            bad_fields = 0;
	int            results_seen = 0;
	int            idle_cycles = 0;
	bit            holding = 1'b0;
	bit            hold_done = 1'b0;

	csi_word_to_double_pair DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// one signed part: normalize by leading one, rebias shared exponent
	function automatic logic [DBL_W-1:0] part_to_bits(input logic sgn,
	                                                 input logic [MAG_W-1:0] mag,
	                                                 input logic [SEXP_W-1:0] sexp);
		logic [MAG_W-1:0]  norm;
		logic [EXPO_W-1:0] expo;
		logic [DBL_W-1:0]  bits;
		int unsigned       lead;
		bits = '0;
		bits[63] = sgn;
		if (mag == '0) begin
			return bits;  // signed zero
		end
		norm = mag;
		lead = 0;
		while (!norm[10] && lead < 10) begin
			norm = norm << 1;
			lead++;
		end
		expo = EXPO_W'(sexp) + 11'd992 - EXPO_W'(lead);
		bits[62:52] = expo;
		bits[51:42] = norm[9:0];
		return bits;
	endfunction

	function automatic double_pair_t word_to_doubles(input logic [WORD_W-1:0] w);
		double_pair_t p;
		p.re_bits = part_to_bits(w[29], w[28:18], w[5:0]);
		p.im_bits = part_to_bits(w[17], w[16:6], w[5:0]);
		return p;
	endfunction

	function automatic logic [WORD_W-1:0] build_word(input logic [1:0] spare, input logic rs,
	                                                 input logic [MAG_W-1:0] rm, input logic is,
	                                                 input logic [MAG_W-1:0] im,
	                                                 input logic [SEXP_W-1:0] e);
		return {spare, rs, rm, is, im, e};
	endfunction

	// append one row to the directed table
	function automatic void add_row(input logic [WORD_W-1:0] w, input bit known,
	                                input logic [DBL_W-1:0] re, input logic [DBL_W-1:0] im);
		stim_row_t r;
		r.word    = w;
		r.known   = known;
		r.re_bits = re;
		r.im_bits = im;
		stim_rows.insert(stim_rows.size(), r);
	endfunction

	// mix of raw words and words aimed at each shift count, zero, one, full scale and exponent ends
	function automatic logic [WORD_W-1:0] rand_word();
		logic [MAG_W-1:0]  rm;
		logic [MAG_W-1:0]  im;
		logic [SEXP_W-1:0] e;
		int unsigned       k;
		rm = MAG_W'($urandom);
		im = MAG_W'($urandom);
		e  = SEXP_W'($urandom);
		case ($urandom_range(0, 9))
			4, 5: begin
				k  = $urandom_range(0, 10);
				rm = (11'd1 << k) | (rm & ((11'd1 << k) - 11'd1));
				k  = $urandom_range(0, 10);
				im = (11'd1 << k) | (im & ((11'd1 << k) - 11'd1));
			end
			6: begin
				if ($urandom_range(0, 1)) rm = '0;
				else im = '0;
			end
			7: begin
				if ($urandom_range(0, 1)) rm = 11'd1;
				else im = 11'd1;
			end
			8: e = $urandom_range(0, 1) ? 6'h3F : 6'h00;
			9: begin
				rm = $urandom_range(0, 1) ? 11'h7FF : 11'h400;
				im = $urandom_range(0, 1) ? 11'h7FF : 11'h001;
			end
			default: ;
		endcase
		return build_word(2'($urandom), 1'($urandom), rm, 1'($urandom), im, e);
	endfunction

	// sender gap: mostly none, some short, few long; none during bursts or the long hold
	function automatic int sender_gap(input int idx);
		int unsigned r;
		if (holding || (idx % 256) < 64) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// offer one item, keep tvalid high straight into it when there is no gap
	task automatic send_word(input logic [WORD_W-1:0] w, input double_pair_t want, input int gap);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= w;
		do @(posedge clk); while (!s_axis_tready);
		pending_doubles.insert(pending_doubles.size(), want);
	endtask

	// stimulus
	initial begin
		double_pair_t want;
		logic [WORD_W-1:0] w;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// typed rows: zero word, all ones, signed zeros, magnitude one at both exponent
		// ends, leading one already on top, spare top bits alone
		add_row(32'h0000_0000, 1'b1, 64'h0, 64'h0);
		add_row(32'hFFFF_FFFF, 1'b1, 64'hC1FF_FC00_0000_0000, 64'hC1FF_FC00_0000_0000);
		add_row(32'h2002_0000, 1'b1, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);
		add_row(32'h0004_0000, 1'b1, 64'h3D60_0000_0000_0000, 64'h0);
		add_row(32'h0000_007F, 1'b1, 64'h0, 64'h4150_0000_0000_0000);
		add_row(32'h1000_0000, 1'b1, 64'h3E00_0000_0000_0000, 64'h0);
		add_row(32'hC000_0000, 1'b1, 64'h0, 64'h0);
		// every shift count on both parts
		for (int k = 0; k <= 10; k++) begin
			add_row(build_word(2'(k), 1'(k), 11'd1 << k, 1'(k + 1), 11'h7FF >> k, 6'(k * 6)),
			        1'b0, 64'h0, 64'h0);
		end
		add_row(build_word(2'b00, 1'b0, 11'h7FF, 1'b1, 11'h000, 6'h00), 1'b0, 64'h0, 64'h0);
		add_row(build_word(2'b01, 1'b1, 11'h001, 1'b0, 11'h7FF, 6'h3F), 1'b0, 64'h0, 64'h0);

		foreach (stim_rows[i]) begin
			if (stim_rows[i].known) want = '{stim_rows[i].re_bits, stim_rows[i].im_bits};
			else want = word_to_doubles(stim_rows[i].word);
			send_word(stim_rows[i].word, want, sender_gap(i));
		end

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			w = rand_word();
			send_word(w, word_to_doubles(w), sender_gap(n));
		end
		s_axis_tvalid <= 1'b0;

		while (pending_doubles.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (bad_fields == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// receiver: runs of ready and stalls, plus one long hold that backs the pipe up
	initial begin
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (!hold_done && results_seen >= HOLD_AFTER) begin
				holding = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				holding = 1'b0;
				hold_done = 1'b1;
			end
			m_axis_tready <= 1'b1;
			if ($urandom_range(0, 19) == 0) repeat ($urandom_range(100, 300)) @(posedge clk);
			else repeat ($urandom_range(1, 8)) @(posedge clk);
			m_axis_tready <= 1'b0;
			if ($urandom_range(0, 9) == 0) repeat ($urandom_range(10, 40)) @(posedge clk);
			else repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	end

	// output check against the oldest expected pair
	always @(posedge clk) begin
		double_pair_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			if (pending_doubles.size() == 0) begin
				$display("%0t: result with nothing expected, actual %h", $time, m_axis_tdata);
				bad_fields++;
			end else begin
				want = pending_doubles.pop_front();
				if (m_axis_tdata[63:0] !== want.re_bits) begin
					$display("%0t: real_double_bits expected %h actual %h",
					         $time, want.re_bits, m_axis_tdata[63:0]);
					bad_fields++;
				end
				if (m_axis_tdata[127:64] !== want.im_bits) begin
					$display("%0t: imag_double_bits expected %h actual %h",
					         $time, want.im_bits, m_axis_tdata[127:64]);
					bad_fields++;
				end
			end
		end
	end

	// watchdog: stuck when neither side moves an item for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

endmodule
